// ===== sv/scb_pkg.sv =====
// ----------------------------------------------------------------------------
// scb_pkg: shared types and constants for the sharded counter bank
// Operation and status codes, sizes.
// ----------------------------------------------------------------------------
package scb_pkg;

    localparam int NUM_IDS     = 64;
    localparam int NUM_THREADS = 8;
    localparam int ID_W        = 6;
    localparam int THR_W       = 3;
    localparam int SHARD_AW    = ID_W + THR_W;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_ADD     = 3'd2,
        OP_READ    = 3'd3,
        OP_RESET   = 3'd4,
        OP_REG     = 3'd5,
        OP_UNREG   = 3'd6,
        OP_NOP     = 3'd7
    } op_t;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_ID       = 3'd1;
    localparam logic [2:0] ST_UNREG        = 3'd2;
    localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
    localparam logic [2:0] ST_NONE_FREE    = 3'd4;
    localparam logic [2:0] ST_ALREADY_REG  = 3'd5;

endpackage

// ===== sv/scb_shard_ram.sv =====
// ----------------------------------------------------------------------------
// scb_shard_ram: per-thread shard storage
// One write port, one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module scb_shard_ram (
    input  logic                     clk,
    input  logic                     we,
    input  logic [scb_pkg::SHARD_AW-1:0] waddr,
    input  logic [63:0]              wdata,
    input  logic [scb_pkg::SHARD_AW-1:0] raddr,
    output logic [63:0]              rdata
);
    import scb_pkg::*;

    logic [63:0] mem [0:(1 << SHARD_AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/scb_shared_ram.sv =====
// ----------------------------------------------------------------------------
// scb_shared_ram: shared counter values
// One write port, one registered read port, reset by a clearing sweep.
// ----------------------------------------------------------------------------
module scb_shared_ram (
    input  logic                 clk,
    input  logic                 we,
    input  logic [scb_pkg::ID_W-1:0] waddr,
    input  logic [63:0]          wdata,
    input  logic [scb_pkg::ID_W-1:0] raddr,
    output logic [63:0]          rdata
);
    import scb_pkg::*;

    logic [63:0] mem [0:NUM_IDS-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sharded_counter_bank.sv =====
// ----------------------------------------------------------------------------
// sharded_counter_bank: bank of 64-bit counters with per-thread shards
// Top level: request channel, result channel, id_limit register, sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with kind, thread, counter_id, amount.
//   Each request gives one result on out_valid/out_stall: status, granted_id,
//   total. The block takes one request at a time: in_stall is high from
//   acceptance until the result has been loaded into the output register.
//   All arithmetic goes through one 64-bit adder/subtractor under a small
//   sequencer. Free/nop are settled at dispatch; alloc scans ids upward
//   from 1 below id_limit; add reads then writes the shard; read and reset
//   walk the 8 thread slots; register clears the thread's row of 64 ids;
//   unregister folds each id's shard into the shared value.
//   After reset a clearing pass over all 64 ids zeroes the shared values;
//   requests are held off meanwhile, id_limit writes are taken at any time.
//   A result stalled by out_stall stays in the output register; the next
//   request may be accepted and worked on, and finishes only once the output
//   register is free.
// ----------------------------------------------------------------------------
module sharded_counter_bank (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 kind,
    input  logic [scb_pkg::THR_W-1:0]  thread,
    input  logic [scb_pkg::ID_W-1:0]   counter_id,
    input  logic [63:0]                amount,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic [scb_pkg::ID_W-1:0]   granted_id,
    output logic [63:0]                total,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [6:0]                 cfg_data
);
    import scb_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN, S_ADD_RD, S_ADD_WR,
        S_SUM_RD, S_SUM_ACC, S_SUM_END, S_ZERO_ROW,
        S_FOLD_RD, S_FOLD_WR, S_DONE
    } state_t;

    state_t state_reg;
    logic [6:0]        limit_reg;
    logic [NUM_IDS-1:0]     free_reg;
    logic [NUM_THREADS-1:0] active_reg;
    logic [2:0]        kind_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [ID_W-1:0]   cid_reg;
    logic [63:0]       amt_reg;
    logic [ID_W:0]     idx_reg;     // id walk, one bit wider for the end
    logic [THR_W:0]    tix_reg;     // thread walk
    logic [63:0]       acc_reg;
    logic [2:0]        st_reg;
    logic [ID_W-1:0]   gid_reg;
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [ID_W-1:0]   granted_reg;
    logic [63:0]       total_reg;

    // memory ports
    logic              sh_we;
    logic [ID_W-1:0]   sh_waddr, sh_raddr;
    logic [63:0]       sh_wdata, sh_rdata;
    logic              sd_we;
    logic [SHARD_AW-1:0] sd_waddr, sd_raddr;
    logic [63:0]       sd_wdata, sd_rdata;

    // shared adder
    logic [63:0] alu_a, alu_b, alu_y;
    logic        alu_sub;

    logic [6:0] eff_lim;
    logic       id_ok;
    logic       thr_act;
    logic       out_free;

    assign eff_lim  = (limit_reg < 7'(NUM_IDS)) ? limit_reg : 7'(NUM_IDS);
    assign id_ok    = (cid_reg != '0) && ({1'b0, cid_reg} < eff_lim);
    assign thr_act  = active_reg[thr_reg];
    assign out_free = !out_valid_reg || !out_stall;
    assign alu_y    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign granted_id = granted_reg;
    assign total      = total_reg;

    scb_shared_ram u_shared (
        .clk   (clk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .raddr (sh_raddr),
        .rdata (sh_rdata)
    );

    scb_shard_ram u_shard (
        .clk   (clk),
        .we    (sd_we),
        .waddr (sd_waddr),
        .wdata (sd_wdata),
        .raddr (sd_raddr),
        .rdata (sd_rdata)
    );

    // memory addressing and write control
    always_comb
    begin
        sh_we    = 1'b0;
        sh_waddr = cid_reg;
        sh_wdata = alu_y;
        sh_raddr = cid_reg;
        sd_we    = 1'b0;
        sd_waddr = {thr_reg, cid_reg};
        sd_wdata = alu_y;
        sd_raddr = {thr_reg, cid_reg};
        alu_a    = acc_reg;
        alu_b    = sd_rdata;
        alu_sub  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                sh_we    = 1'b1;
                sh_waddr = idx_reg[ID_W-1:0];
                sh_wdata = '0;
            end
            S_SCAN:
            begin
                sh_we    = free_reg[idx_reg[ID_W-1:0]] && (idx_reg < eff_lim);
                sh_waddr = idx_reg[ID_W-1:0];
                sh_wdata = '0;
            end
            S_ADD_WR:
            begin
                alu_a = sd_rdata;
                alu_b = amt_reg;
                sd_we = 1'b1;
            end
            S_SUM_RD:
            begin
                sd_raddr = {tix_reg[THR_W-1:0], cid_reg};
            end
            S_SUM_ACC:
            begin
                sd_raddr = {tix_reg[THR_W-1:0], cid_reg};
            end
            S_SUM_END:
            begin
                // reset: shared - (shared + shards) = 0 - shards
                alu_a   = (kind_reg == OP_RESET) ? 64'd0 : sh_rdata;
                alu_b   = acc_reg;
                alu_sub = (kind_reg == OP_RESET);
                sh_we   = (kind_reg == OP_RESET);
            end
            S_ZERO_ROW:
            begin
                sd_we    = 1'b1;
                sd_waddr = {thr_reg, idx_reg[ID_W-1:0]};
                sd_wdata = '0;
            end
            S_FOLD_RD:
            begin
                sh_raddr = idx_reg[ID_W-1:0];
                sd_raddr = {thr_reg, idx_reg[ID_W-1:0]};
            end
            S_FOLD_WR:
            begin
                alu_a    = sh_rdata;
                alu_b    = sd_rdata;
                sh_we    = 1'b1;
                sh_waddr = idx_reg[ID_W-1:0];
                sd_we    = 1'b1;
                sd_waddr = {thr_reg, idx_reg[ID_W-1:0]};
                sd_wdata = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            limit_reg     <= 7'd64;
            free_reg      <= {{(NUM_IDS-1){1'b1}}, 1'b0};
            active_reg    <= '0;
            idx_reg       <= '0;
            tix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (ID_W+1)'(NUM_IDS-1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg  <= kind;
                        thr_reg   <= thread;
                        cid_reg   <= counter_id;
                        amt_reg   <= amount;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    st_reg  <= ST_OK;
                    gid_reg <= '0;
                    acc_reg <= '0;
                    idx_reg <= (ID_W+1)'(1);
                    tix_reg <= '0;
                    state_reg <= S_DONE;
                    case (kind_reg)
                        OP_ALLOC:
                        begin
                            st_reg    <= ST_NONE_FREE;
                            state_reg <= S_SCAN;
                        end
                        OP_FREE:
                        begin
                            if (!id_ok)
                            begin
                                st_reg <= ST_BAD_ID;
                            end
                            else if (free_reg[cid_reg])
                            begin
                                st_reg <= ST_ALREADY_FREE;
                            end
                            else
                            begin
                                free_reg[cid_reg] <= 1'b1;
                            end
                        end
                        OP_ADD:
                        begin
                            if (!thr_act)
                            begin
                                st_reg <= ST_UNREG;
                            end
                            else if (!id_ok)
                            begin
                                st_reg <= ST_BAD_ID;
                            end
                            else
                            begin
                                state_reg <= S_ADD_RD;
                            end
                        end
                        OP_READ, OP_RESET:
                        begin
                            if (!id_ok)
                            begin
                                st_reg <= ST_BAD_ID;
                            end
                            else
                            begin
                                state_reg <= S_SUM_RD;
                            end
                        end
                        OP_REG:
                        begin
                            if (thr_act)
                            begin
                                st_reg <= ST_ALREADY_REG;
                            end
                            else
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_ZERO_ROW;
                            end
                        end
                        OP_UNREG:
                        begin
                            if (!thr_act)
                            begin
                                st_reg <= ST_UNREG;
                            end
                            else
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_FOLD_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SCAN:
                begin
                    if (idx_reg >= eff_lim)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (free_reg[idx_reg[ID_W-1:0]])
                    begin
                        free_reg[idx_reg[ID_W-1:0]] <= 1'b0;
                        gid_reg   <= idx_reg[ID_W-1:0];
                        st_reg    <= ST_OK;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_ADD_RD:
                begin
                    state_reg <= S_ADD_WR;
                end
                S_ADD_WR:
                begin
                    state_reg <= S_DONE;
                end
                S_SUM_RD:
                begin
                    // read of shard slot tix issued; data next cycle
                    state_reg <= S_SUM_ACC;
                end
                S_SUM_ACC:
                begin
                    if (active_reg[tix_reg[THR_W-1:0]])
                    begin
                        acc_reg <= alu_y;
                    end
                    if (tix_reg == (THR_W+1)'(NUM_THREADS-1))
                    begin
                        state_reg <= S_SUM_END;
                    end
                    else
                    begin
                        tix_reg   <= tix_reg + 1'b1;
                        state_reg <= S_SUM_RD;
                    end
                end
                S_SUM_END:
                begin
                    // shared value read is held since dispatch at cid_reg
                    // read: alu gives shared + shards
                    if (kind_reg == OP_READ)
                    begin
                        acc_reg <= alu_y;
                    end
                    state_reg <= S_DONE;
                end
                S_ZERO_ROW:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (ID_W+1)'(NUM_IDS-1))
                    begin
                        active_reg[thr_reg] <= 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_FOLD_RD:
                begin
                    state_reg <= S_FOLD_WR;
                end
                S_FOLD_WR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (ID_W+1)'(NUM_IDS-1))
                    begin
                        active_reg[thr_reg] <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_FOLD_RD;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= st_reg;
                        granted_reg   <= gid_reg;
                        total_reg     <= (kind_reg == OP_READ && st_reg == ST_OK)
                                         ? acc_reg : 64'd0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
